[rtl/core/wht_pkg.sv]
// Shared types, constants and the microcode program of the window hit tester.
package wht_pkg;

   localparam int WHT_WINDOWS = 16;

   localparam int COORD_W  = 32;
   localparam int PARENT_W = 5;
   localparam int HIT_W    = 5;
   localparam logic [HIT_W-1:0] NO_SLOT = 5'd16;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      OP_NOP   = 4'd0,
      OP_LATCH = 4'd1,
      OP_WRITE = 4'd2,
      OP_CLEAR = 4'd3,
      OP_QINIT = 4'd4,
      OP_WALK  = 4'd5,
      OP_READ  = 4'd6,
      OP_ACC   = 4'd7,
      OP_SAT   = 4'd8,
      OP_TEST  = 4'd9,
      OP_NEXT  = 4'd10,
      OP_RESP  = 4'd11
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER     = 4'd0,
      C_ALWAYS    = 4'd1,
      C_NOREQ     = 4'd2,
      C_IS_WRITE  = 4'd3,
      C_IS_CLEAR  = 4'd4,
      C_NOT_QUERY = 4'd5,
      C_UNUSED    = 4'd6,
      C_CHAIN_END = 4'd7,
      C_MORE      = 4'd8,
      C_RSP_BUSY  = 4'd9
   } cond_type;

   typedef logic [3:0] upc_type;

   localparam upc_type A_IDLE     = 4'd0;
   localparam upc_type A_DISP_WR  = 4'd1;
   localparam upc_type A_DISP_CLR = 4'd2;
   localparam upc_type A_DISP_Q   = 4'd3;
   localparam upc_type A_QINIT    = 4'd4;
   localparam upc_type A_WRITE    = 4'd5;
   localparam upc_type A_CLEAR    = 4'd6;
   localparam upc_type A_SLOT     = 4'd7;
   localparam upc_type A_READ     = 4'd8;
   localparam upc_type A_ACC      = 4'd9;
   localparam upc_type A_SAT      = 4'd10;
   localparam upc_type A_TEST     = 4'd11;
   localparam upc_type A_SPARE0   = 4'd12;
   localparam upc_type A_SPARE1   = 4'd13;
   localparam upc_type A_NEXT     = 4'd14;
   localparam upc_type A_RESP     = 4'd15;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   idle;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic is_write;
      logic is_clear;
      logic is_query;
      logic slot_unused;
      logic chain_end;
      logic more_slots;
      logic rsp_busy;
   } status_type;

   typedef struct packed {
      logic [PARENT_W-1:0] parent;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  w;
      logic [COORD_W-1:0]  h;
      logic [COORD_W-1:0]  depth;
      logic                visible;
   } entry_type;

   // jump to target when cond holds, else fall through to the next address
   function automatic uword_type wht_rom(input upc_type addr);
      uword_type u;
      case (addr)
         A_IDLE:     u = '{OP_LATCH, C_NOREQ,     A_IDLE};
         A_DISP_WR:  u = '{OP_NOP,   C_IS_WRITE,  A_WRITE};
         A_DISP_CLR: u = '{OP_NOP,   C_IS_CLEAR,  A_CLEAR};
         A_DISP_Q:   u = '{OP_NOP,   C_NOT_QUERY, A_RESP};
         A_QINIT:    u = '{OP_QINIT, C_ALWAYS,    A_SLOT};
         A_WRITE:    u = '{OP_WRITE, C_ALWAYS,    A_RESP};
         A_CLEAR:    u = '{OP_CLEAR, C_ALWAYS,    A_RESP};
         A_SLOT:     u = '{OP_WALK,  C_UNUSED,    A_NEXT};
         A_READ:     u = '{OP_READ,  C_CHAIN_END, A_SAT};
         A_ACC:      u = '{OP_ACC,   C_ALWAYS,    A_READ};
         A_SAT:      u = '{OP_SAT,   C_NEVER,     A_IDLE};
         A_TEST:     u = '{OP_TEST,  C_ALWAYS,    A_NEXT};
         A_NEXT:     u = '{OP_NEXT,  C_MORE,      A_SLOT};
         A_RESP:     u = '{OP_RESP,  C_RSP_BUSY,  A_RESP};
         default:    u = '{OP_NOP,   C_ALWAYS,    A_IDLE};
      endcase
      return u;
   endfunction

endpackage

[rtl/core/wht_req_if.sv]
// Request channel interface of the window hit tester.
interface wht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [3:0]  slot;
   logic [4:0]  parent_slot;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] size_w;
   logic [31:0] size_h;
   logic [31:0] depth;
   logic        shown;

   modport source (
      output valid, action, slot, parent_slot, pos_x, pos_y, size_w, size_h, depth, shown,
      input  ready
   );
   modport sink (
      input  valid, action, slot, parent_slot, pos_x, pos_y, size_w, size_h, depth, shown,
      output ready
   );
endinterface

[rtl/core/wht_rsp_if.sv]
// Response channel interface of the window hit tester.
interface wht_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [4:0] hit_slot;

   modport source (output valid, found, hit_slot, input ready);
   modport sink (input valid, found, hit_slot, output ready);
endinterface

[rtl/core/wht_useq.sv]
// Microcode sequencer: step counter, program ROM and jump condition select.
module wht_useq import wht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   upc_type   pc_ff;
   upc_type   pc_in;
   uword_type uword;
   logic      take;

   assign uword = wht_rom(pc_ff);

   always_comb begin
      case (uword.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NOREQ:     take = !status.req_valid;
         C_IS_WRITE:  take = status.is_write;
         C_IS_CLEAR:  take = status.is_clear;
         C_NOT_QUERY: take = !status.is_query;
         C_UNUSED:    take = status.slot_unused;
         C_CHAIN_END: take = status.chain_end;
         C_MORE:      take = status.more_slots;
         C_RSP_BUSY:  take = status.rsp_busy;
         default:     take = 1'b1;
      endcase
   end

   assign pc_in = take ? uword.target : pc_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = uword.op;
   assign ctrl.idle = (pc_ff == A_IDLE);

   a_no_spare: assert property (@(posedge clock) disable iff (reset)
      pc_ff != A_SPARE0 && pc_ff != A_SPARE1)
      else $error("sequencer reached an unused step");

   a_acc_after_read: assert property (@(posedge clock) disable iff (reset)
      pc_ff == A_ACC |-> $past(pc_ff) == A_READ)
      else $error("accumulate step without a table read");

   a_resp_to_idle: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == A_RESP && !status.rsp_busy) |=> pc_ff == A_IDLE)
      else $error("sequencer did not return to idle after the response");

endmodule

[rtl/core/wht_dpath.sv]
// Datapath: slot table, chain walk accumulator, hit compare and response register.
module wht_dpath import wht_pkg::*; #(
   parameter int WINDOWS = WHT_WINDOWS
) (
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   output status_type status,
   wht_req_if.sink    req,
   wht_rsp_if.source  rsp
);

   localparam int SLOT_W = $clog2(WINDOWS);
   localparam int PTR_W  = (SLOT_W > PARENT_W) ? SLOT_W : PARENT_W;
   localparam int STEP_W = $clog2(WINDOWS + 1);
   localparam int ACC_W  = $clog2(WINDOWS) + COORD_W + 1;
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   entry_type mem [WINDOWS];
   entry_type rd_ff;

   logic [WINDOWS-1:0] used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff, found_in;
   logic [HIT_W-1:0]   hit_ff, hit_in;
   logic               best_ok_ff, best_ok_in;

   logic [1:0]          action_ff, action_in;
   logic [3:0]          slot_ff, slot_in;
   logic [PARENT_W-1:0] parent_ff, parent_in;
   logic [COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0]  w_ff, w_in, h_ff, h_in, depth_ff, depth_in;
   logic                shown_ff, shown_in;

   logic [SLOT_W-1:0]  i_ff, i_in;
   logic [PTR_W-1:0]   s_ff, s_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               vis_ff, vis_in;
   logic [ACC_W-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [COORD_W-1:0] own_w_ff, own_w_in, own_h_ff, own_h_in, own_z_ff, own_z_in;
   logic [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [SLOT_W-1:0]  best_ff, best_in;
   logic [COORD_W-1:0] best_z_ff, best_z_in;

   logic              accept, slot_ok, link_ok, chain_end, rsp_busy, in_window, wins;
   logic [SLOT_W-1:0] wr_idx;
   entry_type         wdata;
   logic [COORD_W+1:0] px, py, ox, oy, right, bottom;

   assign accept   = req.valid && ctrl.idle;
   assign req.ready = ctrl.idle;
   assign rsp_busy = rsp_valid_ff && !rsp.ready;

   assign slot_ok = 32'(slot_ff) < WINDOWS;
   assign wr_idx  = SLOT_W'(slot_ff);
   assign wdata   = '{parent_ff, x_ff, y_ff, w_ff, h_ff, depth_ff, shown_ff};

   assign link_ok = (s_ff != PTR_W'(NO_SLOT)) && (32'(s_ff) < WINDOWS) &&
                    used_ff[s_ff[SLOT_W-1:0]];
   assign chain_end = !link_ok || (32'(steps_ff) == WINDOWS) || !vis_ff;

   assign px     = {{2{x_ff[COORD_W-1]}}, x_ff};
   assign py     = {{2{y_ff[COORD_W-1]}}, y_ff};
   assign ox     = {{2{ox_ff[COORD_W-1]}}, ox_ff};
   assign oy     = {{2{oy_ff[COORD_W-1]}}, oy_ff};
   assign right  = ox + {2'b00, own_w_ff};
   assign bottom = oy + {2'b00, own_h_ff};
   assign in_window = vis_ff &&
                   ($signed(px) >= $signed(ox)) && ($signed(py) >= $signed(oy)) &&
                   ($signed(px) < $signed(right)) && ($signed(py) < $signed(bottom));
   assign wins   = !best_ok_ff || ($signed(own_z_ff) >= $signed(best_z_ff));

   assign status.req_valid   = req.valid;
   assign status.is_write    = (action_ff == ACT_WRITE);
   assign status.is_clear    = (action_ff == ACT_CLEAR);
   assign status.is_query    = (action_ff == ACT_QUERY);
   assign status.slot_unused = !used_ff[i_ff];
   assign status.chain_end   = chain_end;
   assign status.more_slots  = 32'(i_ff) != WINDOWS - 1;
   assign status.rsp_busy    = rsp_busy;

   always_comb begin
      used_in      = used_ff;
      rsp_valid_in = rsp_busy;
      found_in     = found_ff;
      hit_in       = hit_ff;
      best_ok_in   = best_ok_ff;
      action_in    = action_ff;
      slot_in      = slot_ff;
      parent_in    = parent_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      depth_in     = depth_ff;
      shown_in     = shown_ff;
      i_in         = i_ff;
      s_in         = s_ff;
      steps_in     = steps_ff;
      vis_in       = vis_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      own_w_in     = own_w_ff;
      own_h_in     = own_h_ff;
      own_z_in     = own_z_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      best_in      = best_ff;
      best_z_in    = best_z_ff;
      case (ctrl.op)
         OP_LATCH: begin
            if (accept) begin
               action_in  = req.action;
               slot_in    = req.slot;
               parent_in  = req.parent_slot;
               x_in       = req.pos_x;
               y_in       = req.pos_y;
               w_in       = req.size_w;
               h_in       = req.size_h;
               depth_in   = req.depth;
               shown_in   = req.shown;
               best_ok_in = 1'b0;
            end
         end
         OP_WRITE: begin
            if (slot_ok) used_in[wr_idx] = 1'b1;
         end
         OP_CLEAR: begin
            if (slot_ok) used_in[wr_idx] = 1'b0;
         end
         OP_QINIT: begin
            i_in       = '0;
            best_ok_in = 1'b0;
         end
         OP_WALK: begin
            s_in     = PTR_W'(i_ff);
            steps_in = '0;
            vis_in   = 1'b1;
            acc_x_in = '0;
            acc_y_in = '0;
         end
         OP_ACC: begin
            if (steps_ff == '0) begin
               own_w_in = rd_ff.w;
               own_h_in = rd_ff.h;
               own_z_in = rd_ff.depth;
            end
            vis_in   = rd_ff.visible;
            acc_x_in = acc_x_ff + {{(ACC_W-COORD_W){rd_ff.x[COORD_W-1]}}, rd_ff.x};
            acc_y_in = acc_y_ff + {{(ACC_W-COORD_W){rd_ff.y[COORD_W-1]}}, rd_ff.y};
            s_in     = PTR_W'(rd_ff.parent);
            steps_in = steps_ff + STEP_W'(1);
         end
         OP_SAT: begin
            if ($signed(acc_x_ff) > SAT_HI) ox_in = 32'h7fff_ffff;
            else if ($signed(acc_x_ff) < SAT_LO) ox_in = 32'h8000_0000;
            else ox_in = acc_x_ff[COORD_W-1:0];
            if ($signed(acc_y_ff) > SAT_HI) oy_in = 32'h7fff_ffff;
            else if ($signed(acc_y_ff) < SAT_LO) oy_in = 32'h8000_0000;
            else oy_in = acc_y_ff[COORD_W-1:0];
         end
         OP_TEST: begin
            if (in_window && wins) begin
               best_ok_in = 1'b1;
               best_in    = i_ff;
               best_z_in  = own_z_ff;
            end
         end
         OP_NEXT: begin
            i_in = i_ff + SLOT_W'(1);
         end
         OP_RESP: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               found_in     = best_ok_ff;
               hit_in       = best_ok_ff ? HIT_W'(best_ff) : NO_SLOT;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff   <= found_in;
      hit_ff     <= hit_in;
      best_ok_ff <= best_ok_in;
      action_ff  <= action_in;
      slot_ff    <= slot_in;
      parent_ff  <= parent_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      depth_ff   <= depth_in;
      shown_ff   <= shown_in;
      i_ff       <= i_in;
      s_ff       <= s_in;
      steps_ff   <= steps_in;
      vis_ff     <= vis_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      own_w_ff   <= own_w_in;
      own_h_ff   <= own_h_in;
      own_z_ff   <= own_z_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      best_ff    <= best_in;
      best_z_ff  <= best_z_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_WRITE && slot_ok) mem[wr_idx] <= wdata;
      if (ctrl.op == OP_READ && link_ok) rd_ff <= mem[s_ff[SLOT_W-1:0]];
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = found_ff;
   assign rsp.hit_slot = hit_ff;

   a_found_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (found_ff == (hit_ff != NO_SLOT)))
      else $error("found flag disagrees with hit slot");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_RESP && !rsp_busy) |=> rsp_valid_ff)
      else $error("response step did not load the output register");

   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_busy |=> (rsp_valid_ff && $stable(found_ff) && $stable(hit_ff)))
      else $error("waiting response changed before it was taken");

endmodule

[rtl/core/window_hit_tester_top.sv]
// Window hit tester top level: sequencer and datapath.
// The block keeps WINDOWS window slots. A write or a clear updates the slot table and then
// responds; an unknown action responds without touching the table. A hit query is run by the
// microcode program over every slot in turn through the one-port slot table: an unused slot
// is skipped, a used slot has its chain walk summed over the slots that it visits (itself
// included; the walk stops early at an invisible window) and is then tested. One request is
// in flight at a time; a new one is accepted while the previous response waits in its output
// register. Every request gets exactly one response; queries that miss, writes and clears
// answer found 0 and hit_slot 16.
module window_hit_tester_top import wht_pkg::*; #(
   parameter int WINDOWS = WHT_WINDOWS
) (
   input logic       clock,
   input logic       reset,
   wht_req_if.sink   req,
   wht_rsp_if.source rsp
);

   ctrl_type   ctrl;
   status_type status;

   wht_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   wht_dpath #(.WINDOWS(WINDOWS)) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench of window_hit_tester_top: directed table, then random requests.
`timescale 1ns / 100ps

module tb;
   import wht_pkg::*;

   localparam int WINDOWS          = WHT_WINDOWS;
   localparam int RANDOM_PER_PHASE = 332;
   localparam int NUM_PHASES       = 4;
   localparam int TAIL_CYCLES      = 40;
   // ~1350 requests at worst-case query length plus gaps and stalls, with margin
   localparam longint LIMIT_CYCLES = 3_000_000;

   localparam logic [1:0]         ACT_UNKNOWN = 2'd3;
   localparam logic signed [31:0] COORD_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN   = 32'sh8000_0000;
   localparam longint             SAT_HI      = 64'sd2147483647;
   localparam longint             SAT_LO      = -64'sd2147483648;

   typedef struct packed {
      logic [1:0]         act;
      logic [3:0]         slot;
      logic [4:0]         parent;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0]        w;
      logic [31:0]        h;
      logic signed [31:0] z;
      logic               shown;
   } window_request_type;

   typedef struct packed {
      logic       found;
      logic [4:0] hit_slot;
   } hit_result_type;

   typedef struct packed {
      window_request_type req;
      logic               fixed;
      hit_result_type     hit;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   wht_req_if req_chan ();
   wht_rsp_if rsp_chan ();

   window_hit_tester_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the slot table
   bit                 tbl_used   [WINDOWS];
   logic [4:0]         tbl_parent [WINDOWS];
   logic signed [31:0] tbl_x      [WINDOWS];
   logic signed [31:0] tbl_y      [WINDOWS];
   logic [31:0]        tbl_w      [WINDOWS];
   logic [31:0]        tbl_h      [WINDOWS];
   logic signed [31:0] tbl_z      [WINDOWS];
   bit                 tbl_shown  [WINDOWS];

   hit_result_type   pending_hits [$];
   directed_row_type directed_rows [$];
   int               error_count = 0;
   int               rsp_count = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   longint           cycle_count;

   task automatic report_mismatch(input string msg);
      if (error_count < 100) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic void clear_entry(input int s);
      tbl_used[s]   = 1'b0;
      tbl_parent[s] = '0;
      tbl_x[s]      = '0;
      tbl_y[s]      = '0;
      tbl_w[s]      = '0;
      tbl_h[s]      = '0;
      tbl_z[s]      = '0;
      tbl_shown[s]  = 1'b0;
   endfunction

   function automatic bit link_alive(input logic [4:0] l);
      return (l < WINDOWS) && tbl_used[l[3:0]];
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // updates the table and returns the topmost window under the query point
   function automatic hit_result_type predict_hit(input window_request_type r);
      hit_result_type res;
      longint         px, py, ax, ay, wx, hy, best_z;
      logic [4:0]     link;
      int             i, steps;
      bit             visible;
      res.found    = 1'b0;
      res.hit_slot = NO_SLOT;
      best_z       = SAT_LO;
      case (r.act)
         ACT_WRITE: begin
            tbl_used[r.slot]   = 1'b1;
            tbl_parent[r.slot] = r.parent;
            tbl_x[r.slot]      = r.x;
            tbl_y[r.slot]      = r.y;
            tbl_w[r.slot]      = r.w;
            tbl_h[r.slot]      = r.h;
            tbl_z[r.slot]      = r.z;
            tbl_shown[r.slot]  = r.shown;
         end
         ACT_CLEAR: begin
            clear_entry(r.slot);
         end
         ACT_QUERY: begin
            px = r.x;
            py = r.y;
            for (i = 0; i < WINDOWS; i++) begin
               if (!tbl_used[i]) continue;
               visible = 1'b1;
               ax      = 0;
               ay      = 0;
               steps   = 0;
               link    = 5'(i);
               while (link_alive(link) && steps < WINDOWS) begin
                  steps++;
                  if (!tbl_shown[link[3:0]]) visible = 1'b0;
                  ax   = ax + tbl_x[link[3:0]];
                  ay   = ay + tbl_y[link[3:0]];
                  link = tbl_parent[link[3:0]];
               end
               if (!visible) continue;
               ax = clamp32(ax);
               ay = clamp32(ay);
               wx = tbl_w[i];
               hy = tbl_h[i];
               if (px < ax || py < ay || px >= ax + wx || py >= ay + hy) continue;
               if (res.hit_slot == NO_SLOT || longint'(tbl_z[i]) >= best_z) begin
                  res.found    = 1'b1;
                  res.hit_slot = 5'(i);
                  best_z       = tbl_z[i];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic window_request_type write_req(input logic [3:0] s, input logic [4:0] p,
         input logic [31:0] x, input logic [31:0] y, input logic [31:0] w,
         input logic [31:0] h, input logic [31:0] z, input logic shown);
      window_request_type r;
      r = '{act: ACT_WRITE, slot: s, parent: p, x: x, y: y, w: w, h: h, z: z, shown: shown};
      return r;
   endfunction

   function automatic window_request_type query_req(input logic [31:0] x,
         input logic [31:0] y);
      window_request_type r;
      r     = write_req(4'hA, 5'h1F, x, y, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_0000, 1'b1);
      r.act = ACT_QUERY;
      return r;
   endfunction

   function automatic window_request_type clear_req(input logic [3:0] s);
      window_request_type r;
      r     = write_req(s, NO_SLOT, '1, '1, '1, '1, '1, 1'b1);
      r.act = ACT_CLEAR;
      return r;
   endfunction

   function automatic window_request_type odd_req();
      window_request_type r;
      r     = write_req(4'hF, 5'h1F, '1, '1, '1, '1, '1, 1'b1);
      r.act = ACT_UNKNOWN;
      return r;
   endfunction

   function automatic void row_fixed(input window_request_type r, input logic f,
         input logic [4:0] h);
      directed_rows.push_back('{req: r, fixed: 1'b1, hit: '{found: f, hit_slot: h}});
   endfunction

   function automatic void row_model(input window_request_type r);
      directed_rows.push_back('{req: r, fixed: 1'b0, hit: '{found: 1'b0, hit_slot: NO_SLOT}});
   endfunction

   function automatic logic [31:0] pick_coord();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 82) return 32'($urandom_range(500)) - 32'd200;
      if (sel < 91) return $urandom;
      if (sel < 96) return COORD_MAX - 32'($urandom_range(300));
      return COORD_MIN + 32'($urandom_range(300));
   endfunction

   function automatic logic [31:0] pick_size();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 85) return 32'($urandom_range(300, 1));
      if (sel < 93) return $urandom;
      if (sel < 96) return 32'd0;
      return 32'hFFFF_FFFF - 32'($urandom_range(3));
   endfunction

   function automatic window_request_type random_request();
      window_request_type r;
      int unsigned        sel;
      r.slot   = 4'($urandom_range(15));
      r.parent = 5'($urandom_range(31));
      r.x      = pick_coord();
      r.y      = pick_coord();
      r.w      = $urandom;
      r.h      = $urandom;
      r.z      = $urandom;
      r.shown  = 1'($urandom_range(1));
      sel      = $urandom_range(99);
      if (sel < 44) begin
         r.act = ACT_WRITE;
         sel   = $urandom_range(99);
         if (sel < 55) r.parent = NO_SLOT;
         else if (sel < 95) r.parent = 5'($urandom_range(15));
         else r.parent = 5'($urandom_range(31, 17));
         r.w   = pick_size();
         r.h   = pick_size();
         sel   = $urandom_range(99);
         if (sel < 70) r.z = 32'($urandom_range(7));
         else if (sel < 94) r.z = (sel < 88) ? $urandom : COORD_MAX;
         else r.z = COORD_MIN;
         r.shown = ($urandom_range(99) < 85);
      end else if (sel < 54) begin
         r.act = ACT_CLEAR;
      end else if (sel < 97) begin
         r.act = ACT_QUERY;
      end else begin
         r.act = ACT_UNKNOWN;
      end
      return r;
   endfunction

   task automatic send_request(input window_request_type r, input logic fixed,
         input hit_result_type typed);
      hit_result_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.action      <= r.act;
      req_chan.slot        <= r.slot;
      req_chan.parent_slot <= r.parent;
      req_chan.pos_x       <= r.x;
      req_chan.pos_y       <= r.y;
      req_chan.size_w      <= r.w;
      req_chan.size_h      <= r.h;
      req_chan.depth       <= r.z;
      req_chan.shown       <= r.shown;
      req_chan.valid       <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = predict_hit(r);
      pending_hits.push_back(fixed ? typed : predicted);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      hit_result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_hits.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                      rsp_count));
         end else begin
            want = pending_hits.pop_front();
            if (rsp_chan.found !== want.found)
               report_mismatch($sformatf("response %0d found %b, expected %b",
                                         rsp_count, rsp_chan.found, want.found));
            if (rsp_chan.hit_slot !== want.hit_slot)
               report_mismatch($sformatf("response %0d hit_slot %0d, expected %0d",
                                         rsp_count, rsp_chan.hit_slot, want.hit_slot));
         end
         rsp_count++;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL window_hit_tester_top");
      $finish;
   end

   initial begin
      int phase_send  [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      int i, ph, n;
      phase_send           = '{0, 74, 0, 14};
      phase_stall          = '{0, 0, 74, 14};
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.action      = ACT_WRITE;
      req_chan.slot        = '0;
      req_chan.parent_slot = '0;
      req_chan.pos_x       = '0;
      req_chan.pos_y       = '0;
      req_chan.size_w      = '0;
      req_chan.size_h      = '0;
      req_chan.depth       = '0;
      req_chan.shown       = 1'b0;
      rsp_chan.ready       = 1'b0;
      for (i = 0; i < WINDOWS; i++) clear_entry(i);

      // empty table, unknown action, edges of one window
      row_fixed(query_req(0, 0), 1'b0, NO_SLOT);
      row_fixed(odd_req(), 1'b0, NO_SLOT);
      row_fixed(write_req(4'd0, NO_SLOT, 0, 0, 100, 100, 0, 1'b1), 1'b0, NO_SLOT);
      row_fixed(query_req(0, 0), 1'b1, 5'd0);
      row_fixed(query_req(99, 99), 1'b1, 5'd0);
      row_fixed(query_req(100, 50), 1'b0, NO_SLOT);
      // child at equal depth wins on index, deeper sibling wins on depth
      row_fixed(write_req(4'd15, 5'd0, 10, 10, 20, 20, 0, 1'b1), 1'b0, NO_SLOT);
      row_fixed(query_req(15, 15), 1'b1, 5'd15);
      row_fixed(write_req(4'd3, NO_SLOT, 0, 0, 50, 50, 5, 1'b1), 1'b0, NO_SLOT);
      row_fixed(query_req(15, 15), 1'b1, 5'd3);
      // a hidden window is not hit
      row_fixed(write_req(4'd0, NO_SLOT, 0, 0, 100, 100, 0, 1'b0), 1'b0, NO_SLOT);
      row_fixed(query_req(60, 60), 1'b0, NO_SLOT);
      // orphan after its parent is cleared
      row_fixed(clear_req(4'd0), 1'b0, NO_SLOT);
      row_fixed(write_req(4'd15, 5'd0, 10, 10, 20, 20, 9, 1'b1), 1'b0, NO_SLOT);
      row_model(query_req(12, 12));
      // parent loop
      row_model(write_req(4'd1, 5'd2, 1000, 1000, 30, 30, 3, 1'b1));
      row_model(write_req(4'd2, 5'd1, 1000, 1000, 30, 30, 4, 1'b1));
      row_model(query_req(16005, 16005));
      // out-of-range parent, largest window, zero width
      row_model(write_req(4'd4, 5'd31, COORD_MIN, COORD_MIN, '1, '1, COORD_MAX, 1'b1));
      row_model(write_req(4'd9, NO_SLOT, 0, 0, 0, 5, COORD_MAX, 1'b1));
      row_model(query_req(0, 0));
      // saturation of the summed origin, both directions
      row_model(write_req(4'd5, NO_SLOT, COORD_MAX, COORD_MAX, 10, 10, 100, 1'b1));
      row_model(write_req(4'd6, 5'd5, COORD_MAX, COORD_MAX, 4, 4, COORD_MAX, 1'b1));
      row_model(query_req(COORD_MAX, COORD_MAX));
      row_model(write_req(4'd7, NO_SLOT, COORD_MIN, COORD_MIN, 1, 1, 0, 1'b1));
      row_model(write_req(4'd8, 5'd7, COORD_MIN, COORD_MIN, 1, 1, COORD_MAX, 1'b1));
      row_model(query_req(COORD_MIN, COORD_MIN));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < directed_rows.size(); n++)
         send_request(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].hit);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = phase_send[ph];
         stall_pct     = phase_stall[ph];
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            send_request(random_request(), 1'b0, '{found: 1'b0, hit_slot: NO_SLOT});
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS window_hit_tester_top");
      end else begin
         $display("FAIL window_hit_tester_top");
      end
      $finish;
   end

endmodule
